/* design/srs_pkg.sv */
// Shared types and constants for the weighted service-record selector.
package srs_pkg;

  localparam int PRIO_W   = 16;
  localparam int WEIGHT_W = 16;
  localparam int PORT_W   = 16;
  localparam int TGT_W    = 8;
  localparam int RND_W    = 32;
  localparam int LEFT_W   = 5;
  localparam int DIV_CNT_W = 6;

  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(RND_W);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic                operation;
    logic [PRIO_W-1:0]   priority_req;
    logic [WEIGHT_W-1:0] weight;
    logic [PORT_W-1:0]   port;
    logic [TGT_W-1:0]    target_id;
    logic [RND_W-1:0]    random_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [PRIO_W-1:0]   chosen_priority;
    logic [WEIGHT_W-1:0] chosen_weight;
    logic [PORT_W-1:0]   chosen_port;
    logic [TGT_W-1:0]    chosen_target;
    logic [LEFT_W-1:0]   records_left;
  } out_item_t;

  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [WEIGHT_W-1:0] weight;
    logic [PORT_W-1:0]   port;
    logic [TGT_W-1:0]    target;
  } rec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_DIV_INIT,
    ST_DIV,
    ST_PICK_INIT,
    ST_PICK,
    ST_SHIFT_INIT,
    ST_SHIFT,
    ST_DONE
  } fsm_state_t;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_run;
    logic div_init;
    logic div_run;
    logic pick_init;
    logic pick_run;
    logic shift_init;
    logic shift_run;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_pop;
    logic empty;
    logic multi;
    logic scan_done;
    logic div_done;
    logic pick_done;
    logic shift_done;
    logic out_free;
  } sts_t;

endpackage

/* design/srs_ctrl.sv */
// Sequencer for insert and pop: steps the datapath through scan, divide, pick and compaction.
module srs_ctrl
  import srs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.is_pop && !sts.empty) state_nxt = ST_SCAN;
        else state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = sts.multi ? ST_DIV_INIT : ST_PICK_INIT;
      end
      ST_DIV_INIT:   state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_PICK_INIT;
      end
      ST_PICK_INIT:  state_nxt = ST_PICK;
      ST_PICK: begin
        if (sts.pick_done) state_nxt = ST_SHIFT_INIT;
      end
      ST_SHIFT_INIT: state_nxt = ST_SHIFT;
      ST_SHIFT: begin
        if (sts.shift_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DECIDE:     cmd.scan_init  = 1'b1;
      ST_SCAN:       cmd.scan_run   = 1'b1;
      ST_DIV_INIT:   cmd.div_init   = 1'b1;
      ST_DIV:        cmd.div_run    = 1'b1;
      ST_PICK_INIT:  cmd.pick_init  = 1'b1;
      ST_PICK:       cmd.pick_run   = 1'b1;
      ST_SHIFT_INIT: cmd.shift_init = 1'b1;
      ST_SHIFT:      cmd.shift_run  = 1'b1;
      ST_DONE:       cmd.finish     = sts.out_free;
      default:       cmd = '0;
    endcase
  end

endmodule

/* design/srs_dpath.sv */
// Record table, scan accumulators, restoring divider, pick logic and result register.
module srs_dpath
  import srs_pkg::*;
#(
  parameter int MAX_RECORDS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  in_item_t  in_data,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int IDX_W = $clog2(MAX_RECORDS);
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int TOT_W = WEIGHT_W + CNT_W;

  rec_t mem [MAX_RECORDS];

  in_item_t           item_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   ptr_r;
  logic               vld_r;
  logic [IDX_W-1:0]   vidx_r;
  rec_t               rd_data_r;
  logic [PRIO_W-1:0]  best_r;
  logic [CNT_W-1:0]   ncand_r;
  logic [TOT_W-1:0]   total_r;
  logic [TOT_W-1:0]   rem_r;
  logic [RND_W-1:0]   dvd_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [TOT_W-1:0]   run_r;
  logic               picked_r;
  logic [IDX_W-1:0]   pick_idx_r;
  rec_t               chosen_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic               full, empty, zero_mode, issue, out_free;
  logic [TOT_W-1:0]   dsr, r_eff, inc, run_nxt;
  logic [TOT_W:0]     rem_sh, diff;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  rec_t               wr_data, in_rec;
  out_item_t          res;
  logic [31:0]        cnt_ext;

  assign full      = (count_r == CNT_W'(MAX_RECORDS));
  assign empty     = (count_r == '0);
  assign zero_mode = (total_r == '0);
  assign out_free  = !out_valid_r || out_ready;
  assign issue     = (cmd.scan_run || cmd.pick_run || cmd.shift_run) && (ptr_r < count_r);

  // Divisor is the candidate count when every candidate weight is zero.
  assign dsr    = zero_mode ? TOT_W'(ncand_r) : total_r;
  assign rem_sh = {rem_r, dvd_r[RND_W-1]};
  assign diff   = rem_sh - {1'b0, dsr};
  assign r_eff  = (ncand_r > CNT_W'(1)) ? rem_r : '0;
  assign inc    = zero_mode ? TOT_W'(1) : TOT_W'(rd_data_r.weight);
  assign run_nxt = run_r + inc;

  assign in_rec = '{prio: item_r.priority_req, weight: item_r.weight,
                    port: item_r.port, target: item_r.target_id};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[IDX_W-1:0];
    wr_data = in_rec;
    if (cmd.shift_run && vld_r) begin
      wr_en   = 1'b1;
      wr_addr = vidx_r - IDX_W'(1);
      wr_data = rd_data_r;
    end else if (cmd.finish && item_r.operation == OP_INSERT && !full) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (issue) rd_data_r <= mem[ptr_r[IDX_W-1:0]];
  end

  // Result formed at commit time.
  always_comb begin
    res       = '0;
    count_nxt = count_r;
    if (item_r.operation == OP_INSERT) begin
      if (full) begin
        res.status = STAT_FULL;
      end else begin
        res.status = STAT_OK;
        count_nxt  = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        res.status = STAT_EMPTY;
      end else begin
        res.status          = STAT_OK;
        res.chosen_priority = chosen_r.prio;
        res.chosen_weight   = chosen_r.weight;
        res.chosen_port     = chosen_r.port;
        res.chosen_target   = chosen_r.target;
        count_nxt           = count_r - CNT_W'(1);
      end
    end
    cnt_ext          = 32'(count_nxt);
    res.records_left = cnt_ext[LEFT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r <= issue;
      if (cmd.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.finish) out_r <= res;

    if (issue) begin
      ptr_r  <= ptr_r + CNT_W'(1);
      vidx_r <= ptr_r[IDX_W-1:0];
    end
    if (cmd.scan_init || cmd.pick_init) ptr_r <= '0;
    if (cmd.shift_init) ptr_r <= CNT_W'(pick_idx_r) + CNT_W'(1);

    // Running minimum: a new lowest priority restarts the candidate tallies.
    if (cmd.scan_init) begin
      ncand_r <= '0;
      total_r <= '0;
    end else if (cmd.scan_run && vld_r) begin
      if (ncand_r == '0 || rd_data_r.prio < best_r) begin
        best_r  <= rd_data_r.prio;
        ncand_r <= CNT_W'(1);
        total_r <= TOT_W'(rd_data_r.weight);
      end else if (rd_data_r.prio == best_r) begin
        ncand_r <= ncand_r + CNT_W'(1);
        total_r <= total_r + TOT_W'(rd_data_r.weight);
      end
    end

    // Restoring divider, one quotient bit a cycle; only the remainder is kept.
    if (cmd.div_init) begin
      rem_r     <= '0;
      dvd_r     <= item_r.random_value;
      div_cnt_r <= DIV_STEPS;
    end else if (cmd.div_run && div_cnt_r != '0) begin
      rem_r     <= diff[TOT_W] ? rem_sh[TOT_W-1:0] : diff[TOT_W-1:0];
      dvd_r     <= {dvd_r[RND_W-2:0], 1'b0};
      div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
    end

    // Weighted pick: first candidate whose running sum passes the remainder.
    if (cmd.pick_init) begin
      run_r      <= '0;
      picked_r   <= 1'b0;
      pick_idx_r <= '0;
    end else if (cmd.pick_run && vld_r && !picked_r && rd_data_r.prio == best_r) begin
      run_r <= run_nxt;
      if (r_eff < run_nxt) begin
        picked_r   <= 1'b1;
        pick_idx_r <= vidx_r;
        chosen_r   <= rd_data_r;
      end
    end
  end

  always_comb begin
    sts            = '0;
    sts.is_pop     = (item_r.operation == OP_POP);
    sts.empty      = empty;
    sts.multi      = (ncand_r > CNT_W'(1));
    sts.scan_done  = (ptr_r >= count_r) && !vld_r;
    sts.div_done   = (div_cnt_r == '0);
    sts.pick_done  = (ptr_r >= count_r) && !vld_r;
    sts.shift_done = (ptr_r >= count_r) && !vld_r;
    sts.out_free   = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* design/srv_record_weighted_selector.sv */
// Top level of the weighted service-record selector.
// This block holds up to MAX_RECORDS service records (priority, weight, port, target
// handle) in insertion order and answers every input beat with exactly one result beat.
// An insert appends a record, or reports full and drops it. A pop takes the records
// sharing the lowest priority: one candidate is taken as is, all-zero weights pick
// candidate random mod count, otherwise the first candidate whose running weight sum
// exceeds random mod total weight wins; the record is removed and the rest close up.
// One item is in work at a time. An insert passes through accept, decide and commit;
// its result beat is registered at commit, once the result register is free.
// A pop, when several records tie at the lowest priority, runs one table scan for
// the minimum priority and weight total, a 32-step restoring divider for the
// remainder, a second scan for the pick, and a compaction pass that moves each
// later record down one slot, all through the single read and single write port of
// the record memory. A pop with a single candidate skips the divider. The result
// register parts the two sides, so a new beat may be accepted while a result waits.
module srv_record_weighted_selector
  import srs_pkg::*;
#(
  parameter int MAX_RECORDS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t cmd;
  sts_t sts;

  // Sequence the steps of each item.
  srs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the table and do the arithmetic.
  srs_dpath #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
